>>> rtl/triangle_opposite_angle_cotangent_unit_defines.svh
// Assertion macros for the triangle cotangent unit.
`ifndef TRIANGLE_OPPOSITE_ANGLE_COTANGENT_UNIT_DEFINES_SVH
`define TRIANGLE_OPPOSITE_ANGLE_COTANGENT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TOAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TOAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TOAC_ASSERT_IMP(lbl, ante, cons, msg)
`define TOAC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/toac_pkg.sv
// Shared constants and types of the triangle cotangent unit.
package toac_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS = 16;
	localparam int COT_W = 32;
	localparam logic [COT_W-1:0] COT_MAX = 32'h7FFF_FFFF;
	localparam logic [COT_W-1:0] COT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic saturated;
		logic degenerate;
	} cot_flags_t;
endpackage

>>> rtl/toac_vec.sv
// Edge vectors, dot product, cross product and its squared length.
module toac_vec #(
	parameter int CB = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic                in_bnd,
	input  logic [9*CB-1:0]     in_pts,
	output logic                out_v,
	output logic                out_bnd,
	output logic                out_dneg,
	output logic [2*CB+1:0]     out_mag,
	output logic [4*CB+3:0]     out_sum
);
	localparam int UW  = CB + 1;
	localparam int PW  = 2 * UW;
	localparam int DTW = PW + 2;
	localparam int CW  = PW + 1;
	localparam int MW  = 2 * CB + 2;
	localparam int H   = CB + 1;
	localparam int SQW = 2 * MW;
	localparam int SW  = SQW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic bnd_s1, bnd_s2, bnd_s3, bnd_s4, bnd_s5, bnd_s6, bnd_s7;

	logic signed [UW-1:0]  u_s1 [3];
	logic signed [UW-1:0]  w_s1 [3];
	logic signed [PW-1:0]  d_s2 [3];
	logic signed [PW-1:0]  ca_s2 [3];
	logic signed [PW-1:0]  cb_s2 [3];
	logic signed [DTW-1:0] dot_s3;
	logic signed [CW-1:0]  c_s3 [3];
	logic                  dneg_s4, dneg_s5, dneg_s6, dneg_s7;
	logic [MW-1:0]         mag_s4, mag_s5, mag_s6, mag_s7;
	logic [MW-1:0]         cm_s4 [3];
	logic [2*H-1:0]        hh_s5 [3];
	logic [2*H-1:0]        hl_s5 [3];
	logic [2*H-1:0]        ll_s5 [3];
	logic [SQW-1:0]        sq_s6 [3];
	logic [SW-1:0]         sum_s7;

	logic signed [UW-1:0]  u_c [3];
	logic signed [UW-1:0]  w_c [3];
	logic signed [DTW-1:0] dot_c;
	logic [MW-1:0]         cm_c [3];

	for (genvar i = 0; i < 3; i++) begin : g_edge
		logic signed [CB-1:0] pa, pt, ph;
		assign pa = in_pts[i*CB +: CB];
		assign pt = in_pts[(3+i)*CB +: CB];
		assign ph = in_pts[(6+i)*CB +: CB];
		assign u_c[i] = UW'(pt) - UW'(pa);
		assign w_c[i] = UW'(ph) - UW'(pa);
		assign cm_c[i] = c_s3[i][CW-1] ? MW'(-c_s3[i]) : MW'(c_s3[i]);
	end

	assign dot_c = DTW'(d_s2[0]) + DTW'(d_s2[1]) + DTW'(d_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bnd_s1 <= in_bnd;
			bnd_s2 <= bnd_s1;
			bnd_s3 <= bnd_s2;
			bnd_s4 <= bnd_s3;
			bnd_s5 <= bnd_s4;
			bnd_s6 <= bnd_s5;
			bnd_s7 <= bnd_s6;
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= u_c[i];
				w_s1[i] <= w_c[i];
				d_s2[i] <= u_s1[i] * w_s1[i];
				c_s3[i] <= CW'(ca_s2[i]) - CW'(cb_s2[i]);
				cm_s4[i] <= cm_c[i];
				hh_s5[i] <= cm_s4[i][MW-1 -: H] * cm_s4[i][MW-1 -: H];
				hl_s5[i] <= cm_s4[i][MW-1 -: H] * cm_s4[i][H-1:0];
				ll_s5[i] <= cm_s4[i][H-1:0] * cm_s4[i][H-1:0];
				sq_s6[i] <= (SQW'(hh_s5[i]) << (2*H)) + (SQW'(hl_s5[i]) << (H+1))
					+ SQW'(ll_s5[i]);
			end
			ca_s2[0] <= u_s1[1] * w_s1[2];
			cb_s2[0] <= u_s1[2] * w_s1[1];
			ca_s2[1] <= u_s1[2] * w_s1[0];
			cb_s2[1] <= u_s1[0] * w_s1[2];
			ca_s2[2] <= u_s1[0] * w_s1[1];
			cb_s2[2] <= u_s1[1] * w_s1[0];
			dot_s3 <= dot_c;
			dneg_s4 <= dot_s3[DTW-1];
			mag_s4 <= dot_s3[DTW-1] ? MW'(-dot_s3) : MW'(dot_s3);
			dneg_s5 <= dneg_s4;
			mag_s5 <= mag_s4;
			dneg_s6 <= dneg_s5;
			mag_s6 <= mag_s5;
			dneg_s7 <= dneg_s6;
			mag_s7 <= mag_s6;
			sum_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		end
	end

	assign out_v    = v_s7;
	assign out_bnd  = bnd_s7;
	assign out_dneg = dneg_s7;
	assign out_mag  = mag_s7;
	assign out_sum  = sum_s7;
endmodule

>>> rtl/toac_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module toac_isqrt #(
	parameter int SW = 100,
	parameter int XW = 52
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [SW-1:0]   in_rad,
	input  logic [XW-1:0]   in_side,
	output logic            out_v,
	output logic [SW/2-1:0] out_root,
	output logic [XW-1:0]   out_side
);
	localparam int RW  = SW / 2;
	localparam int RMW = RW + 2;

	logic            vld_s  [RW];
	logic [SW-1:0]   rad_s  [RW];
	logic [RMW-1:0]  rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [XW-1:0]   side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic           v_in;
		logic [SW-1:0]  rad_in;
		logic [RMW-1:0] rem_in;
		logic [RW-1:0]  root_in;
		logic [XW-1:0]  side_in;
		logic [RMW+1:0] cur, trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign cur   = {rem_in, rad_in[SW-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_in << 2;
				rem_s[k]  <= ge ? RMW'(cur - trial) : RMW'(cur);
				root_s[k] <= {root_in[RW-2:0], ge};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_v    = vld_s[RW-1];
	assign out_root = root_s[RW-1];
	assign out_side = side_s[RW-1];
endmodule

>>> rtl/toac_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module toac_div
	import toac_pkg::*;
#(
	parameter int RW = 50,
	parameter int MW = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic             in_bnd,
	input  logic             in_dneg,
	input  logic [MW-1:0]    in_mag,
	input  logic [RW-1:0]    in_len,
	output logic             out_v,
	output logic [COT_W-1:0] out_cot,
	output cot_flags_t       out_flags
);
	localparam int NW = MW + FRAC_BITS;

	logic          vld_s  [NW];
	logic          bnd_s  [NW];
	logic          dneg_s [NW];
	logic          dz_s   [NW];
	logic [NW-1:0] num_s  [NW];
	logic [RW-1:0] rem_s  [NW];
	logic [NW-1:0] q_s    [NW];
	logic [RW-1:0] len_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          v_in, bnd_in, dneg_in, dz_in;
		logic [NW-1:0] num_in, q_in;
		logic [RW-1:0] rem_in, len_in;
		logic [RW:0]   cur;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign bnd_in  = in_bnd;
			assign dneg_in = in_dneg;
			assign dz_in   = in_mag == '0;
			assign num_in  = {in_mag, {FRAC_BITS{1'b0}}};
			assign q_in    = '0;
			assign rem_in  = '0;
			assign len_in  = in_len;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign bnd_in  = bnd_s[k-1];
			assign dneg_in = dneg_s[k-1];
			assign dz_in   = dz_s[k-1];
			assign num_in  = num_s[k-1];
			assign q_in    = q_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign len_in  = len_s[k-1];
		end

		assign cur = {rem_in, num_in[NW-1]};
		assign ge  = cur >= {1'b0, len_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				bnd_s[k]  <= bnd_in;
				dneg_s[k] <= dneg_in;
				dz_s[k]   <= dz_in;
				num_s[k]  <= num_in << 1;
				rem_s[k]  <= ge ? RW'(cur - {1'b0, len_in}) : RW'(cur);
				q_s[k]    <= {q_in[NW-2:0], ge};
				len_s[k]  <= len_in;
			end
		end
	end

	logic [NW-1:0]    q_f;
	logic [COT_W-1:0] lim, q_lo, cot_c;
	logic             big;
	cot_flags_t       flags_c;
	logic             v_q;
	logic [COT_W-1:0] cot_q;
	cot_flags_t       flags_q;

	assign q_f  = q_s[NW-1];
	assign q_lo = q_f[COT_W-1:0];
	assign big  = |q_f[NW-1:COT_W];
	assign lim  = dneg_s[NW-1] ? COT_MIN : COT_MAX;

	always_comb begin
		cot_c = '0;
		flags_c = '0;
		if (bnd_s[NW-1]) begin
			cot_c = '0;
		end else if (len_s[NW-1] == '0) begin
			flags_c.degenerate = 1'b1;
			if (!dz_s[NW-1]) begin
				flags_c.saturated = 1'b1;
				cot_c = lim;
			end
		end else if (big || q_lo > lim) begin
			flags_c.saturated = 1'b1;
			cot_c = lim;
		end else begin
			cot_c = dneg_s[NW-1] ? -q_lo : q_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vld_s[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cot_q   <= cot_c;
			flags_q <= flags_c;
		end
	end

	assign out_v     = v_q;
	assign out_cot   = cot_q;
	assign out_flags = flags_q;
endmodule

>>> rtl/triangle_opposite_angle_cotangent_unit.sv
// Top level of the triangle cotangent unit: pipeline and output skid stage.
// Cotangent of the angle at the apex p0 of a triangle, in signed Q16.16, from three
// corner points given as signed coordinates. One transfer is taken every cycle while
// the skid register is empty. The pipeline has 2*COORD_BITS + 2 square-root stages
// plus 2*COORD_BITS + 18 divider stages plus 9 stages for vectors, products, output
// format and output register. A result waiting on m_tready does not stop input
// until the one-entry skid register behind the pipeline is also full.
`include "triangle_opposite_angle_cotangent_unit_defines.svh"
module triangle_opposite_angle_cotangent_unit
	import toac_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// apex_x, apex_y, apex_z, tail_x, tail_y, tail_z, head_x, head_y, head_z
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	// on_boundary
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// cotangent
	output logic [COT_W-1:0]                     m_tdata,
	// degenerate, saturated
	output logic [1:0]                           m_tuser
);
	localparam int MW = 2 * COORD_BITS + 2;
	localparam int SW = 4 * COORD_BITS + 4;
	localparam int RW = SW / 2;

	logic             en;
	logic             vec_v, vec_bnd, vec_dneg;
	logic [MW-1:0]    vec_mag;
	logic [SW-1:0]    vec_sum;
	logic             sq_v;
	logic [RW-1:0]    sq_root;
	logic [MW+1:0]    sq_side;
	logic             pipe_v;
	logic [COT_W-1:0] pipe_cot;
	cot_flags_t       pipe_flags;

	logic             out_v_q, skid_v_q;
	logic [COT_W-1:0] out_cot_q, skid_cot_q;
	cot_flags_t       out_flags_q, skid_flags_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	toac_vec #(.CB(COORD_BITS)) u_vec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(s_tvalid && en), .in_bnd(s_tuser),
		.in_pts(s_tdata[9*COORD_BITS-1:0]),
		.out_v(vec_v), .out_bnd(vec_bnd), .out_dneg(vec_dneg),
		.out_mag(vec_mag), .out_sum(vec_sum)
	);

	toac_isqrt #(.SW(SW), .XW(MW+2)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(vec_v), .in_rad(vec_sum), .in_side({vec_bnd, vec_dneg, vec_mag}),
		.out_v(sq_v), .out_root(sq_root), .out_side(sq_side)
	);

	toac_div #(.RW(RW), .MW(MW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(sq_v), .in_bnd(sq_side[MW+1]), .in_dneg(sq_side[MW]),
		.in_mag(sq_side[MW-1:0]), .in_len(sq_root),
		.out_v(pipe_v), .out_cot(pipe_cot), .out_flags(pipe_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_v;
			end
		end else if (en && pipe_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_cot_q   <= skid_cot_q;
				out_flags_q <= skid_flags_q;
			end else begin
				out_cot_q   <= pipe_cot;
				out_flags_q <= pipe_flags;
			end
		end else if (en && pipe_v) begin
			skid_cot_q   <= pipe_cot;
			skid_flags_q <= pipe_flags;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_cot_q;
	assign m_tuser  = out_flags_q;

	`TOAC_ASSERT_IMP(a_skid_has_out, skid_v_q, out_v_q, "skid full with output empty")
	`TOAC_ASSERT_IMP(a_sat_value, m_tvalid && m_tuser[1], m_tdata == COT_MAX || m_tdata == COT_MIN, "saturated result not at a limit")
	`TOAC_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser[0] && !m_tuser[1], m_tdata == '0, "degenerate result with zero dot not zero")
	`TOAC_ASSERT_NEXT(a_drain, out_v_q && m_tready && !skid_v_q && !pipe_v, !out_v_q, "output valid without a new transfer")
endmodule

>>> test/triangle_opposite_angle_cotangent_unit_test.sv
// Testbench of the triangle cotangent unit: random and directed triangles, checked per result.
`timescale 1ns / 1ps
module triangle_opposite_angle_cotangent_unit_test
	import toac_pkg::*;
();

	localparam int CB = 24;
	localparam int DW = ((9*CB+7)/8)*8;

	typedef struct {
		logic          boundary;
		logic [DW-1:0] coords;
		bit            drain;
	} tri_t;

	typedef struct {
		logic [COT_W-1:0] cot;
		logic             degen;
		logic             sat;
	} cot_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [COT_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	tri_t tri_q[$];
	cot_t cot_q[$];
	int errors = 0;
	int results = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 0;
	bit in_fire = 0;

	triangle_opposite_angle_cotangent_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata),   // apex_x..z, tail_x..z, head_x..z
		.s_tuser(s_tuser),   // on_boundary
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata),   // cotangent
		.m_tuser(m_tuser)    // degenerate, saturated
	);

	always #10 clk = ~clk;

	function automatic logic [159:0] isqrt(logic [159:0] n);
		logic [159:0] res, bitv, t;
		res = '0;
		for (int k = 158; k >= 0; k -= 2) begin
			bitv = 160'd1 << k;
			t = res + bitv;
			if (n >= t) begin
				n = n - t;
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	function automatic cot_t predict_cotangent(logic boundary, logic [DW-1:0] d);
		logic signed [159:0] p[9];
		logic signed [159:0] u[3];
		logic signed [159:0] v[3];
		logic signed [159:0] dot, cx, cy, cz;
		logic [159:0] s, len, mag, q, lim;
		cot_t r;
		r = '{default: '0};
		if (boundary) return r;
		for (int i = 0; i < 9; i++) p[i] = $signed(d[i*CB +: CB]);
		for (int i = 0; i < 3; i++) begin
			u[i] = p[3+i] - p[i];
			v[i] = p[6+i] - p[i];
		end
		dot = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
		cx = u[1]*v[2] - u[2]*v[1];
		cy = u[2]*v[0] - u[0]*v[2];
		cz = u[0]*v[1] - u[1]*v[0];
		s = cx*cx + cy*cy + cz*cz;
		len = isqrt(s);
		mag = dot[159] ? -dot : dot;
		lim = dot[159] ? 160'h8000_0000 : 160'h7FFF_FFFF;
		if (len == 0) begin
			r.degen = 1;
			if (dot != 0) begin
				r.sat = 1;
				r.cot = dot[159] ? COT_MIN : COT_MAX;
			end
		end else begin
			q = (mag << FRAC_BITS) / len;
			if (q > lim) begin
				r.sat = 1;
				r.cot = lim[31:0];
			end else begin
				r.cot = dot[159] ? -q[31:0] : q[31:0];
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [CB-1:0] rnd_coord(int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'($signed($urandom_range(0, 511)) - 256);
			default: return CB'($signed($urandom_range(0, 131071)) - 65536);
		endcase
	endfunction

	task automatic add_tri(logic b, logic [CB-1:0] c[9], bit drain = 0);
		tri_t t;
		t.boundary = b;
		t.drain = drain;
		for (int i = 0; i < 9; i++) t.coords[i*CB +: CB] = c[i];
		tri_q.push_back(t);
	endtask

	task automatic add_random(bit drain);
		logic [CB-1:0] c[9];
		int kind, mode, k;
		kind = $urandom_range(0, 99);
		mode = $urandom_range(0, 2);
		for (int i = 0; i < 9; i++) c[i] = rnd_coord(mode);
		if (kind < 10) begin
			// collinear: head on the line through apex and tail
			k = $signed($urandom_range(0, 8)) - 4;
			for (int i = 0; i < 3; i++) begin
				c[i] = rnd_coord(1);
				c[3+i] = c[i] + rnd_coord(1);
				c[6+i] = CB'(c[i] + k * $signed(c[3+i] - c[i]));
			end
		end else if (kind < 20) begin
			// nearly collinear: long edges, tiny offset
			for (int i = 0; i < 3; i++) begin
				c[i] = rnd_coord(2);
				c[3+i] = c[i] + rnd_coord(2);
				c[6+i] = CB'(c[3+i] + $signed($urandom_range(0, 2)) - 1);
			end
		end
		add_tri(kind >= 93, c, drain);
	endtask

	task automatic add_uniform(logic b, logic [CB-1:0] val);
		logic [CB-1:0] c[9];
		for (int i = 0; i < 9; i++) c[i] = val;
		add_tri(b, c);
	endtask

	task automatic fill_stimulus();
		logic [CB-1:0] c[9];
		add_uniform(0, 0);
		add_uniform(0, 24'h7FFFFF);
		add_uniform(0, 24'h800000);
		add_uniform(1, 24'hFFFFFF);
		c = '{0, 0, 0, 24'h10000, 0, 0, 0, 24'h10000, 0};
		add_tri(0, c);
		add_tri(1, c);
		c = '{0, 0, 0, 24'h10000, 24'h10000, 0, 0, 24'h10000, 0};
		add_tri(0, c);
		c = '{0, 0, 0, 24'h10000, 0, 0, 24'h20000, 0, 0};
		add_tri(0, c);
		c = '{0, 0, 0, 24'h10000, 0, 0, 24'hFE0000, 0, 0};
		add_tri(0, c);
		c = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE};
		add_tri(0, c);
		c = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			24'h800000, 24'h800001, 24'h800000};
		add_tri(0, c);
		c = '{24'h800000, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 0,
			0, 24'h7FFFFF, 24'h800000};
		add_tri(0, c);
		c = '{24'h800000, 0, 0, 24'h7FFFFF, 0, 0, 24'h800000, 24'h7FFFFF, 0};
		add_tri(0, c);
		c = '{0, 0, 0, 24'h7FFFFF, 0, 0, 24'h800000, 1, 0};
		add_tri(0, c);
		for (int i = 0; i < 10; i++) add_random(0);
		for (int i = 0; i < 1950; i++) add_random(i == 1000);
	endtask

	always @(posedge clk) begin
		cot_t w;
		in_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) cot_q.push_back(predict_cotangent(s_tuser, s_tdata));
		if (m_tvalid && m_tready) begin
			results <= results + 1;
			if (cot_q.size() == 0) begin
				report("unexpected result", m_tdata, 0);
			end else begin
				w = cot_q.pop_front();
				if (m_tdata !== w.cot) report("cotangent", m_tdata, w.cot);
				if (m_tuser[0] !== w.degen) report("degenerate", m_tuser[0], w.degen);
				if (m_tuser[1] !== w.sat) report("saturated", m_tuser[1], w.sat);
			end
		end
	end

	always @(negedge clk) begin
		tri_t t;
		if (arst_n) begin
			if (s_tvalid && !in_fire) begin
			end else if (send_gap > 0) begin
				s_tvalid <= 0;
				send_gap <= send_gap - 1;
			end else if (tri_q.size() > 0 && !(tri_q[0].drain && cot_q.size() > 0)) begin
				t = tri_q.pop_front();
				s_tdata <= t.coords;
				s_tuser <= t.boundary;
				s_tvalid <= 1;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results >= 600) begin
				hold_done <= 1;
				hold_left <= 400;
				m_tready <= 0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				recv_gap <= pick_gap();
			end
		end
	end

	initial begin
		fill_stimulus();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (tri_q.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		while (cot_q.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("triangle_opposite_angle_cotangent_unit regression: pass");
		else
			$display("triangle_opposite_angle_cotangent_unit regression: fail");
		$finish;
	end

	initial begin
		#8ms;
		$display("triangle_opposite_angle_cotangent_unit regression: fail");
		$finish;
	end
endmodule
